FILE: rtl/core/fbab_pkg.sv
// ----------------------------------------------------------------------------
// Alpha blend pixel writer package
// Field widths, register indexes, reset values and the per-channel helper
// functions shared by the pixel writer.
// ----------------------------------------------------------------------------
package fbab_pkg;

    // Field widths of the data path.
    localparam int BPP_W     = 3;
    localparam int SCAN_W    = 15;
    localparam int SHIFT_W   = 5;
    localparam int SIZE_W    = 4;
    localparam int CHAN_W    = 8;
    localparam int PIXEL_W   = 32;
    localparam int ADDR_W    = 26;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 15;

    // Supported pixel sizes in bytes.
    localparam logic [BPP_W-1:0] BPP_ONE  = 3'd1;
    localparam logic [BPP_W-1:0] BPP_TWO  = 3'd2;
    localparam logic [BPP_W-1:0] BPP_FOUR = 3'd4;

    // Largest usable channel field size.
    localparam logic [SIZE_W-1:0] MAX_SIZE = 4'd8;

    // Alpha value of a fully opaque source, also the blend divisor.
    localparam logic [CHAN_W-1:0] ALPHA_MAX = 8'd255;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYTES_PER_PIXEL = 4'd0,
        CFG_SCAN_LINE_BYTES = 4'd1,
        CFG_RED_SHIFT       = 4'd2,
        CFG_RED_SIZE        = 4'd3,
        CFG_GREEN_SHIFT     = 4'd4,
        CFG_GREEN_SIZE      = 4'd5,
        CFG_BLUE_SHIFT      = 4'd6,
        CFG_BLUE_SIZE       = 4'd7
    } t_cfg_idx;

    // Configuration register file.
    typedef struct packed {
        logic [BPP_W-1:0]   bytes_per_pixel;
        logic [SCAN_W-1:0]  scan_line_bytes;
        logic [SHIFT_W-1:0] red_shift;
        logic [SIZE_W-1:0]  red_size;
        logic [SHIFT_W-1:0] green_shift;
        logic [SIZE_W-1:0]  green_size;
        logic [SHIFT_W-1:0] blue_shift;
        logic [SIZE_W-1:0]  blue_size;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        bytes_per_pixel: 3'd4,
        scan_line_bytes: 15'd4096,
        red_shift:       5'd16,
        red_size:        4'd8,
        green_shift:     5'd8,
        green_size:      4'd8,
        blue_shift:      5'd0,
        blue_size:       4'd8
    };

    // Field sizes above eight behave as eight.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
        return (size > MAX_SIZE) ? MAX_SIZE : size;
    endfunction

    // Reduce an 8-bit channel to its field size by dropping low bits.
    function automatic logic [CHAN_W-1:0] reduce_chan(input logic [CHAN_W-1:0] c8,
                                                      input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] s;
        s = eff_size(size);
        return c8 >> (MAX_SIZE - s);
    endfunction

    // Mask with as many ones as the effective field size.
    function automatic logic [CHAN_W-1:0] field_mask(input logic [SIZE_W-1:0] size);
        logic [CHAN_W:0] m;
        m = ({{CHAN_W{1'b0}}, 1'b1} << eff_size(size)) - {{CHAN_W{1'b0}}, 1'b1};
        return m[CHAN_W-1:0];
    endfunction

    // Pull one field out of the old pixel.
    function automatic logic [CHAN_W-1:0] old_field(input logic [PIXEL_W-1:0] p,
                                                    input logic [SHIFT_W-1:0] shift,
                                                    input logic [SIZE_W-1:0]  size);
        logic [PIXEL_W-1:0] t;
        t = p >> shift;
        return t[CHAN_W-1:0] & field_mask(size);
    endfunction

    // Mix one channel: (c*a + old*(255-a)) / 255. The divide is done as
    // (v + 1 + (v >> 8)) >> 8, which is exact for every v up to 255*255.
    function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] c,
                                                     input logic [CHAN_W-1:0] old,
                                                     input logic [CHAN_W-1:0] a);
        logic [2*CHAN_W-1:0] v;
        logic [2*CHAN_W:0]   q;
        v = (2*CHAN_W)'(c) * (2*CHAN_W)'(a)
          + (2*CHAN_W)'(old) * ((2*CHAN_W)'(ALPHA_MAX) - (2*CHAN_W)'(a));
        q = (2*CHAN_W+1)'(v) + (2*CHAN_W+1)'(1) + (2*CHAN_W+1)'(v >> CHAN_W);
        return q[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage

FILE: rtl/core/framebuffer_pixel_alpha_blend_unit.sv
// ----------------------------------------------------------------------------
// Framebuffer pixel alpha blend unit
// Computes the byte address of a pixel and the repacked pixel word to write,
// either an opaque color write or an alpha blend with the old pixel.
// ----------------------------------------------------------------------------
// A word accepted on i_start passes the input register, then the result
// register, before its result is strobed on o_valid.
// Throughput: one word per cycle; o_busy is never raised and the result
// stage cannot be stalled by the receiver.
// Reset (synchronous, active low) clears both valid flags and loads the
// configuration registers with their default values.
module framebuffer_pixel_alpha_blend_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Command channel
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_operation,
    input  logic [COORD_BITS-1:0]           i_pos_x,
    input  logic [COORD_BITS-1:0]           i_pos_y,
    input  logic [fbab_pkg::CHAN_W-1:0]     i_red,
    input  logic [fbab_pkg::CHAN_W-1:0]     i_green,
    input  logic [fbab_pkg::CHAN_W-1:0]     i_blue,
    input  logic [fbab_pkg::CHAN_W-1:0]     i_alpha,
    input  logic [fbab_pkg::PIXEL_W-1:0]    i_dest_pixel,
    // Result channel
    output logic                            o_valid,
    output logic [fbab_pkg::ADDR_W-1:0]     o_byte_address,
    output logic [fbab_pkg::PIXEL_W-1:0]    o_new_pixel,
    output logic                            o_size_error,
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fbab_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbab_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    localparam int XB_W  = COORD_BITS + fbab_pkg::BPP_W;
    localparam int YB_W  = COORD_BITS + fbab_pkg::SCAN_W;
    localparam int SUM_W = (YB_W + 1 > fbab_pkg::ADDR_W) ? YB_W + 1 : fbab_pkg::ADDR_W;

    fbab_pkg::t_cfg r_cfg, n_cfg;

    logic                          r_in_valid;
    logic                          r_op;
    logic [COORD_BITS-1:0]         r_x, r_y;
    logic [fbab_pkg::CHAN_W-1:0]   r_r8, r_g8, r_b8, r_a;
    logic [fbab_pkg::PIXEL_W-1:0]  r_dest;

    logic                          r_out_valid;
    logic [fbab_pkg::ADDR_W-1:0]   r_addr, n_addr;
    logic [fbab_pkg::PIXEL_W-1:0]  r_pixel, n_pixel;
    logic                          r_err, n_err;

    logic                          accept;
    logic [XB_W-1:0]               xb;
    logic [YB_W-1:0]               yb;
    logic [SUM_W-1:0]              addr_sum;
    logic [fbab_pkg::PIXEL_W-1:0]  pmask, old_pix;
    logic [fbab_pkg::CHAN_W-1:0]   red_c, green_c, blue_c;
    logic [fbab_pkg::CHAN_W-1:0]   red_n, green_n, blue_n;
    logic [fbab_pkg::CHAN_W-1:0]   red_p, green_p, blue_p;
    logic [fbab_pkg::PIXEL_W-1:0]  packed_pix;

    // The unit takes a word every cycle and a config write at any time.
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    // Configuration register write decode.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (fbab_pkg::t_cfg_idx'(i_cfg_index))
                fbab_pkg::CFG_BYTES_PER_PIXEL:
                    n_cfg.bytes_per_pixel = i_cfg_data[fbab_pkg::BPP_W-1:0];
                fbab_pkg::CFG_SCAN_LINE_BYTES:
                    n_cfg.scan_line_bytes = i_cfg_data[fbab_pkg::SCAN_W-1:0];
                fbab_pkg::CFG_RED_SHIFT:
                    n_cfg.red_shift = i_cfg_data[fbab_pkg::SHIFT_W-1:0];
                fbab_pkg::CFG_RED_SIZE:
                    n_cfg.red_size = i_cfg_data[fbab_pkg::SIZE_W-1:0];
                fbab_pkg::CFG_GREEN_SHIFT:
                    n_cfg.green_shift = i_cfg_data[fbab_pkg::SHIFT_W-1:0];
                fbab_pkg::CFG_GREEN_SIZE:
                    n_cfg.green_size = i_cfg_data[fbab_pkg::SIZE_W-1:0];
                fbab_pkg::CFG_BLUE_SHIFT:
                    n_cfg.blue_shift = i_cfg_data[fbab_pkg::SHIFT_W-1:0];
                fbab_pkg::CFG_BLUE_SIZE:
                    n_cfg.blue_size = i_cfg_data[fbab_pkg::SIZE_W-1:0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    // Control state: config registers and the two valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= fbab_pkg::CFG_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_in_valid  <= accept;
            r_out_valid <= r_in_valid;
        end
    end

    // Input register captures the command word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_operation;
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_r8   <= i_red;
            r_g8   <= i_green;
            r_b8   <= i_blue;
            r_a    <= i_alpha;
            r_dest <= i_dest_pixel;
        end
    end

    // Byte address: x * bytes_per_pixel + y * scan_line_bytes, wrapped.
    assign xb       = XB_W'(r_x) * XB_W'(r_cfg.bytes_per_pixel);
    assign yb       = YB_W'(r_y) * YB_W'(r_cfg.scan_line_bytes);
    assign addr_sum = SUM_W'(xb) + SUM_W'(yb);
    assign n_addr   = addr_sum[fbab_pkg::ADDR_W-1:0];

    // Pixel width mask; any other size is flagged.
    always_comb begin
        n_err = 1'b0;
        pmask = '0;
        unique case (r_cfg.bytes_per_pixel)
            fbab_pkg::BPP_ONE:  pmask = 32'h0000_00FF;
            fbab_pkg::BPP_TWO:  pmask = 32'h0000_FFFF;
            fbab_pkg::BPP_FOUR: pmask = 32'hFFFF_FFFF;
            default:            n_err = 1'b1;
        endcase
    end

    assign old_pix = r_dest & pmask;

    // Reduce the source channels to their field sizes.
    assign red_c   = fbab_pkg::reduce_chan(r_r8, r_cfg.red_size);
    assign green_c = fbab_pkg::reduce_chan(r_g8, r_cfg.green_size);
    assign blue_c  = fbab_pkg::reduce_chan(r_b8, r_cfg.blue_size);

    // Blend each channel with the matching old field.
    assign red_n   = fbab_pkg::blend_chan(red_c,
                         fbab_pkg::old_field(old_pix, r_cfg.red_shift, r_cfg.red_size), r_a);
    assign green_n = fbab_pkg::blend_chan(green_c,
                         fbab_pkg::old_field(old_pix, r_cfg.green_shift, r_cfg.green_size), r_a);
    assign blue_n  = fbab_pkg::blend_chan(blue_c,
                         fbab_pkg::old_field(old_pix, r_cfg.blue_shift, r_cfg.blue_size), r_a);

    // Select opaque or blended channels and pack them; overflow bits drop off.
    assign red_p   = r_op ? red_n   : red_c;
    assign green_p = r_op ? green_n : green_c;
    assign blue_p  = r_op ? blue_n  : blue_c;

    assign packed_pix = (fbab_pkg::PIXEL_W'(red_p)   << r_cfg.red_shift)
                      | (fbab_pkg::PIXEL_W'(green_p) << r_cfg.green_shift)
                      | (fbab_pkg::PIXEL_W'(blue_p)  << r_cfg.blue_shift);

    // Final pixel: unchanged on a size error, raw blue byte for an opaque
    // one-byte pixel, otherwise the packed fields cut to the pixel width.
    always_comb begin
        priority if (n_err) begin
            n_pixel = r_dest;
        end else if (!r_op && (r_cfg.bytes_per_pixel == fbab_pkg::BPP_ONE)) begin
            n_pixel = fbab_pkg::PIXEL_W'(r_b8);
        end else begin
            n_pixel = packed_pix & pmask;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_addr  <= n_addr;
            r_pixel <= n_pixel;
            r_err   <= n_err;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_byte_address = r_addr;
    assign o_new_pixel    = r_pixel;
    assign o_size_error   = r_err;

    // A result appears only for an accepted command word, after it has passed the input and result registers.
    a_result_follows_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy && i_rst_n, 2))
        else $error("result strobe without a command two cycles earlier");

    // A flagged pixel size passes the old pixel through untouched.
    a_error_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_size_error) |-> (o_new_pixel == $past(i_dest_pixel, 2)))
        else $error("size error result differs from the old pixel");

endmodule
